>>> rtl/hsec_pkg.sv
// ----------------------------------------------------------------------------
// hsec_pkg
// Shared types and constants for the SECDED (79,71) byte stream encoder.
// ----------------------------------------------------------------------------
package hsec_pkg;

  localparam int DATA_BITS  = 71;
  localparam int CODE_BITS  = 78;
  localparam int CHECK_BITS = 7;
  localparam int BYTE_BITS  = 8;
  localparam int UPPER_BITS = 15;
  localparam int LOWER_BITS = 64;
  localparam int TDATA_BITS = 80;
  localparam int FILL_BITS  = $clog2(DATA_BITS);

  typedef logic [DATA_BITS-1:0]   data_word_t;
  typedef logic [CODE_BITS:0]     code_word_t;
  typedef logic [FILL_BITS-1:0]   fill_t;

  // one gathered data word waiting to be encoded
  typedef struct packed {
    logic       final_w;
    data_word_t data;
  } word_ent_t;

  // words handed from the gather stage to the word queue
  typedef struct packed {
    logic      push0;
    logic      push1;
    word_ent_t word0;
    word_ent_t word1;
  } push_t;

  // positions covered by check bit j (one-based index has bit j set)
  function automatic logic [CODE_BITS-1:0] check_mask(input int j);
    logic [CODE_BITS-1:0] m;
    m = '0;
    for (int p = 0; p < CODE_BITS; p++) begin
      m[p] = (((p + 1) >> j) & 1) != 0;
    end
    return m;
  endfunction

endpackage

>>> rtl/hsec_gather.sv
// ----------------------------------------------------------------------------
// hsec_gather
// Packs message bytes, msb first, into 71-bit data words and hands out up to
// two finished words per accepted byte.
// ----------------------------------------------------------------------------
module hsec_gather (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [hsec_pkg::BYTE_BITS-1:0]       data_byte,
  input  logic                                 last_byte,
  output hsec_pkg::push_t                      push
);

  hsec_pkg::data_word_t             data_r, data_nxt;
  hsec_pkg::fill_t                  fill_r, fill_nxt;
  logic [hsec_pkg::BYTE_BITS-1:0]   rev;
  logic [hsec_pkg::BYTE_BITS-1:0]   tail;
  hsec_pkg::data_word_t             merged;
  logic                             complete;
  logic [2:0]                       rem;

  // byte reversed so that arrival order matches word bit order
  always_comb begin
    for (int t = 0; t < hsec_pkg::BYTE_BITS; t++) begin
      rev[t] = data_byte[hsec_pkg::BYTE_BITS-1-t];
    end
  end

  // merge the byte into the pending word and split off any overflow
  always_comb begin
    merged   = data_r | (hsec_pkg::data_word_t'(rev) << fill_r);
    complete = fill_r >= hsec_pkg::fill_t'(hsec_pkg::DATA_BITS - hsec_pkg::BYTE_BITS);
    rem      = 3'(fill_r - hsec_pkg::fill_t'(hsec_pkg::DATA_BITS - hsec_pkg::BYTE_BITS));
    tail     = rev >> (4'(hsec_pkg::BYTE_BITS) - {1'b0, rem});
  end

  // words for the queue
  always_comb begin
    push.push0         = accept && (complete || last_byte);
    push.push1         = accept && last_byte && complete && (rem != 3'd0);
    push.word0.data    = merged;
    push.word0.final_w = last_byte && (!complete || (rem == 3'd0));
    push.word1.data    = hsec_pkg::data_word_t'(tail);
    push.word1.final_w = 1'b1;
  end

  // next pending word and fill count
  always_comb begin
    data_nxt = data_r;
    fill_nxt = fill_r;
    if (accept) begin
      if (last_byte) begin
        data_nxt = '0;
        fill_nxt = '0;
      end else if (complete) begin
        data_nxt = hsec_pkg::data_word_t'(tail);
        fill_nxt = hsec_pkg::fill_t'(rem);
      end else begin
        data_nxt = merged;
        fill_nxt = fill_r + hsec_pkg::fill_t'(hsec_pkg::BYTE_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
      fill_r <= '0;
    end else begin
      data_r <= data_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

>>> rtl/hsec_enc.sv
// ----------------------------------------------------------------------------
// hsec_enc
// Spreads a data word over codeword positions, forms the seven check bits and
// the overall parity, and lays the result out in stream order.
// ----------------------------------------------------------------------------
module hsec_enc (
  input  hsec_pkg::data_word_t   data,
  output hsec_pkg::code_word_t   code
);

  logic [hsec_pkg::CODE_BITS-1:0]  spread;
  logic [hsec_pkg::CODE_BITS-1:0]  full;
  logic [hsec_pkg::CHECK_BITS-1:0] chk;
  logic                            par;
  logic [hsec_pkg::FILL_BITS-1:0]  d;

  // data bits into the non power-of-two positions
  always_comb begin
    d = '0;
    for (int p = 0; p < hsec_pkg::CODE_BITS; p++) begin
      if ((((p + 1) & p)) == 0) begin
        spread[p] = 1'b0;
      end else begin
        spread[p] = data[d];
        d = d + 1'b1;
      end
    end
  end

  // check bits and overall parity
  always_comb begin
    for (int j = 0; j < hsec_pkg::CHECK_BITS; j++) begin
      chk[j] = ^(spread & hsec_pkg::check_mask(j));
    end
    full = spread;
    for (int j = 0; j < hsec_pkg::CHECK_BITS; j++) begin
      full[(1 << j) - 1] = chk[j];
    end
    par = ^full;
  end

  // upper field: position 0 at its msb; lower field: parity at bit 0
  always_comb begin
    for (int i = 0; i < hsec_pkg::UPPER_BITS; i++) begin
      code[i] = full[hsec_pkg::UPPER_BITS-1-i];
    end
    code[hsec_pkg::UPPER_BITS] = par;
    for (int i = 1; i < hsec_pkg::LOWER_BITS; i++) begin
      code[hsec_pkg::UPPER_BITS+i] = full[hsec_pkg::CODE_BITS-i];
    end
  end

endmodule

>>> rtl/hamming_secded_79_71_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// hamming_secded_79_71_stream_encoder_top
// Byte stream to extended Hamming SECDED (79,71) codeword encoder.
// ----------------------------------------------------------------------------
// Message bytes arrive one per transaction, msb first, and are packed into
// 71-bit data words; each full word leaves as one 79-bit codeword (seven
// check bits at positions 2^j-1 plus an overall parity bit). A byte with
// tlast set flushes any leftover bits as a zero-padded word, and the last
// codeword of the message carries tlast. One byte is accepted every cycle
// while in_tready is high; a byte that finishes a word is packed in its
// accept cycle, written into a four-entry word queue, and then encoded into
// the output register. A closing byte can yield two codewords; the output
// delivers one per cycle while out_tready is high, and in_tready drops only
// while fewer than two queue slots are free.
// ----------------------------------------------------------------------------
module hamming_secded_79_71_stream_encoder_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,  // data_byte
  input  logic                                 in_tlast,  // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [hsec_pkg::TDATA_BITS-1:0]      out_tdata, // code_upper, code_lower
  output logic                                 out_tlast  // final_word
);

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  logic                        in_acc;
  hsec_pkg::push_t             push;
  hsec_pkg::word_ent_t         q_mem [QDEPTH];
  logic [QPTR_BITS-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]          cnt_r, cnt_nxt;
  logic                        pop;
  hsec_pkg::word_ent_t         head;
  hsec_pkg::code_word_t        code;
  logic                        out_valid_r, out_valid_nxt;
  hsec_pkg::code_word_t        out_code_r;
  logic                        out_last_r;

  assign in_tready = cnt_r <= (QPTR_BITS+1)'(QDEPTH - 2);
  assign in_acc    = in_tvalid && in_tready;

  hsec_gather u_gather (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push)
  );

  // word queue pointers and fill level
  always_comb begin
    pop        = (cnt_r != '0) && (!out_valid_r || out_tready);
    wr_ptr_nxt = wr_ptr_r + QPTR_BITS'(push.push0) + QPTR_BITS'(push.push1);
    rd_ptr_nxt = rd_ptr_r + QPTR_BITS'(pop);
    cnt_nxt    = cnt_r + (QPTR_BITS+1)'(push.push0) + (QPTR_BITS+1)'(push.push1)
                 - (QPTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_mem[wr_ptr_r] <= push.word0;
    end
    if (push.push1) begin
      q_mem[wr_ptr_r + 1'b1] <= push.word1;
    end
  end

  assign head = q_mem[rd_ptr_r];

  hsec_enc u_enc (
    .data (head.data),
    .code (code)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_code_r <= code;
      out_last_r <= head.final_w;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_code_r};
  assign out_tlast  = out_last_r;

endmodule

>>> rtl/hsec_checker.sv
// ----------------------------------------------------------------------------
// hsec_checker
// Port-level checks for the SECDED stream encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hsec_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [hsec_pkg::TDATA_BITS-1:0]  out_tdata,
  input logic                             out_tlast
);

  // a stalled codeword holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled codeword changed");

  // every codeword has even overall parity
  a_even_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(^out_tdata[hsec_pkg::CODE_BITS:0]))
    else $error("codeword parity odd");

  // padding bit above the codeword stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[hsec_pkg::TDATA_BITS-1])
    else $error("tdata padding set");

  // nothing leaves straight after reset, and input is ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("busy after reset");

endmodule

bind hamming_secded_79_71_stream_encoder_top hsec_checker u_hsec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
